// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

	localparam int IDX_W      = 12;
	localparam int OP_W       = 2;
	localparam int CFG_W      = 10;
	localparam int BYTE_SHIFT = 3;

	localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_MARK    = 2'd2
	} bba_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_MOD_RD,
		ST_MOD_WR,
		ST_RESP
	} bba_state_t;

endpackage

// ===== hw/rtl/bba_if.sv =====
// Request and response channel interfaces for the bitmap block allocator.
interface bba_req_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [IDX_W-1:0] target_block;

	modport source(output valid, output operation, output target_block, input ready);
	modport sink(input valid, input operation, input target_block, output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] granted_block;
	logic             status;

	modport source(output valid, output granted_block, output status, input ready);
	modport sink(input valid, input granted_block, input status, output ready);
endinterface

// ===== hw/rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== hw/rtl/bba_find.sv =====
// First clear bit of one bitmap word, limited to blocks below the active limit.
module bba_find #(
	parameter int WORD_BITS = 32,
	parameter int LW        = 13,
	parameter int BP_W      = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [LW-1:0]        base,
	input  logic [LW-1:0]        limit,
	output logic                 found,
	output logic [BP_W-1:0]      pos
);
	logic [LW-1:0]        rem;
	logic [WORD_BITS-1:0] free;

	always_comb begin
		rem = (limit > base) ? (limit - base) : '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			free[b] = ~word[b] & (LW'(b) < rem);
		end
		found = |free;
		pos   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free[b]) begin
				pos = BP_W'(b);
			end
		end
	end
endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      operation, target_block
//   rsp      out  valid/ready      granted_block, status
//   cfg      in   cfg_wr_en        cfg_wr_data (active_bitmap_bytes)
//
// One request at a time. Allocate: bitmap words are scanned through the RAM read port,
// one per cycle (at most MAX_BLOCKS / WORD_BITS words), then the result is loaded.
// Release and mark: read, write, load; unknown operation or out-of-range index: load
// only. req.ready rises with rsp.valid. After reset a clearing pass writes zero to every
// word, one per cycle, with req.ready low.
// A result waits in the output register; the next request is taken meanwhile.
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bba_pkg::CFG_W-1:0] cfg_wr_data,
	bba_req_if.sink                   req,
	bba_rsp_if.source                 rsp
);
	import bba_pkg::*;

	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BP_W      = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(MAX_BLOCKS + WORD_BITS + 1);
	localparam int LW        = (CNT_W > CFG_W + BYTE_SHIFT) ? CNT_W : CFG_W + BYTE_SHIFT;
	localparam int RECIP_SH  = IDX_W + BP_W;
	localparam int RECIP_W   = RECIP_SH + 1;
	localparam int RECIP     = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W    = IDX_W + RECIP_W;

	bba_state_t state_q, state_d;

	logic [AW-1:0]        addr_q;
	logic [LW-1:0]        base_q;
	logic [LW-1:0]        lim_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 mark_q;
	logic [BP_W-1:0]      r_q;
	logic [IDX_W-1:0]     res_grant_q;
	logic                 res_status_q;
	logic                 rsp_valid_q;
	logic [IDX_W-1:0]     rsp_grant_q;
	logic                 rsp_status_q;
	logic [CFG_W-1:0]     bytes_q;

	logic                 accept;
	logic                 idx_ok;
	logic [LW-1:0]        bytes8;
	logic [LW-1:0]        lim_now;
	logic [PROD_W-1:0]    prod;
	logic [IDX_W-1:0]     qwb;
	logic [LW-1:0]        nxt_base;
	logic                 more;
	logic                 found;
	logic [BP_W-1:0]      pos;
	logic                 out_load;
	logic                 req_ready;
	logic                 wr_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] pos_bit;
	logic [WORD_BITS-1:0] r_bit;

	assign accept   = req.valid & req_ready;
	assign idx_ok   = 32'(req.target_block) < MAX_BLOCKS;
	assign bytes8   = LW'({bytes_q, {BYTE_SHIFT{1'b0}}});
	assign lim_now  = (bytes8 > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : bytes8;
	assign prod     = PROD_W'(req.target_block) * PROD_W'(RECIP);
	assign qwb      = IDX_W'(32'(addr_q) * 32'(WORD_BITS));
	assign nxt_base = base_q + LW'(WORD_BITS);
	assign more     = nxt_base < lim_q;
	assign out_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);
	assign pos_bit  = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
	assign r_bit    = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_q;

	bba_find #(
		.WORD_BITS(WORD_BITS),
		.LW       (LW),
		.BP_W     (BP_W)
	) u_find (
		.word (rd_data),
		.base (base_q),
		.limit(lim_q),
		.found(found),
		.pos  (pos)
	);

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == AW'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.operation == OP_ALLOC) begin
						state_d = ST_SCAN_RD;
					end else if ((req.operation == OP_RELEASE || req.operation == OP_MARK)
							&& idx_ok) begin
						state_d = ST_MOD_RD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				if (found || !more) begin
					state_d = ST_RESP;
				end
			end
			ST_MOD_RD: state_d = ST_MOD_WR;
			ST_MOD_WR: state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		wr_en     = 1'b0;
		wr_data   = '0;
		rd_addr   = addr_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_SCAN_EV: begin
				rd_addr = addr_q + AW'(1);
				wr_en   = found;
				wr_data = rd_data | pos_bit;
			end
			ST_MOD_WR: begin
				wr_en   = 1'b1;
				wr_data = mark_q ? (rd_data | r_bit) : (rd_data & ~r_bit);
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			rsp_valid_q <= 1'b0;
			bytes_q     <= CFG_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				bytes_q <= cfg_wr_data;
			end
			if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + AW'(1);
			end else if (accept) begin
				addr_q <= (req.operation == OP_ALLOC) ? '0 : prod[RECIP_SH +: AW];
			end else if (state_q == ST_SCAN_EV && !found && more) begin
				addr_q <= addr_q + AW'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q        <= req.target_block;
			mark_q       <= (req.operation == OP_MARK);
			base_q       <= '0;
			lim_q        <= lim_now;
			res_grant_q  <= req.target_block;
			res_status_q <= 1'b0;
		end
		if (state_q == ST_SCAN_EV) begin
			if (found) begin
				res_grant_q <= IDX_W'(base_q + LW'(pos));
			end else if (more) begin
				base_q <= nxt_base;
			end else begin
				res_grant_q  <= '0;
				res_status_q <= 1'b1;
			end
		end
		if (state_q == ST_MOD_RD) begin
			r_q <= BP_W'(idx_q - qwb);
		end
		if (out_load) begin
			rsp_grant_q  <= res_grant_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.granted_block = rsp_grant_q;
	assign rsp.status        = rsp_status_q;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit bitmap block allocator: directed and random requests.
module tb;
	import bba_pkg::*;

	localparam int MAX_BLOCKS   = 4096;
	localparam int WORD_BITS    = 32;
	localparam int NUM_WORDS    = MAX_BLOCKS / WORD_BITS;
	localparam int IDLE_PCT     = 13;
	localparam int PHASE_ITEMS  = 130;
	localparam int NUM_PHASES   = 10;
	localparam int STEADY_PHASE = 4;
	localparam int DRAIN_CYCLES = NUM_WORDS + 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PRINT_CAP    = 40;

	localparam int PHASE_BYTES [NUM_PHASES] = '{2, 4, 16, 0, 1023, 3, 40, 512, 0, 1};

	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] block;
		logic             no_space;
	} grant_t;

	class bitmap_tracker;
		logic [WORD_BITS-1:0] used_words [NUM_WORDS];
		logic [CFG_W-1:0]     active_bytes;
		grant_t               grants_due [$];
		int                   mismatches;

		function new();
			foreach (used_words[i])
				used_words[i] = '0;
			active_bytes = CFG_RESET;
			mismatches   = 0;
		endfunction

		function int pending();
			return grants_due.size();
		endfunction

		function grant_t first_fit_alloc();
			int unsigned span;
			grant_t      g;
			span = int'(active_bytes) << BYTE_SHIFT;
			if (span > MAX_BLOCKS)
				span = MAX_BLOCKS;
			g.block    = '0;
			g.no_space = 1'b1;
			for (int unsigned b = 0; b < span && g.no_space; b++) begin
				if (!used_words[b / WORD_BITS][b % WORD_BITS]) begin
					used_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
					g.block    = IDX_W'(b);
					g.no_space = 1'b0;
				end
			end
			return g;
		endfunction

		function void book_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
			grant_t g;
			g.block    = idx;
			g.no_space = 1'b0;
			if (op == OP_ALLOC)
				g = first_fit_alloc();
			else if ((op == OP_RELEASE || op == OP_MARK) && idx < MAX_BLOCKS)
				used_words[idx / WORD_BITS][idx % WORD_BITS] = (op == OP_MARK);
			grants_due.push_back(g);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_CAP)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_grant(logic [IDX_W-1:0] block, logic no_space);
			grant_t want;
			if (grants_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result block=%0d status=%0b",
					block, no_space));
				return;
			end
			want = grants_due.pop_front();
			if (block !== want.block)
				report_mismatch($sformatf("granted_block %0d, want %0d", block, want.block));
			if (no_space !== want.no_space)
				report_mismatch($sformatf("status %0b, want %0b (block %0d)",
					no_space, want.no_space, want.block));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             steady;
	int               cycles;
	bitmap_tracker    book;

	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	bitmap_block_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.WORD_BITS (WORD_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
				book.check_grant(rsp_ch.granted_block, rsp_ch.status);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.operation    = op;
		req_ch.target_block = idx;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		book.book_request(op, idx);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_active_bytes(input logic [CFG_W-1:0] bytes);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = bytes;
		@(negedge clk);
		cfg_wr_en         = 1'b0;
		book.active_bytes = bytes;
	endtask

	task automatic random_phase(input logic [CFG_W-1:0] bytes, input int count);
		int unsigned      span;
		int unsigned      low_span;
		int unsigned      r;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		wait_drained();
		write_active_bytes(bytes);
		span = int'(bytes) << BYTE_SHIFT;
		if (span > MAX_BLOCKS)
			span = MAX_BLOCKS;
		if (span == 0)
			span = 8;
		low_span = (span < 64) ? span : 64;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				op = OP_ALLOC;
			else if (r < 80)
				op = OP_RELEASE;
			else if (r < 95)
				op = OP_MARK;
			else
				op = OP_UNDEF;
			r = $urandom_range(0, 99);
			if (r < 50)
				idx = IDX_W'($urandom_range(0, low_span - 1));
			else if (r < 85)
				idx = IDX_W'($urandom_range(0, span - 1));
			else
				idx = IDX_W'($urandom);
			send_request(op, idx);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] bytes;

		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		steady              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_ALLOC;
		req_ch.target_block = '0;
		book                = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		write_active_bytes(CFG_RESET);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '1);
		send_request(OP_RELEASE, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_MARK, '1);
		send_request(OP_MARK, '1);
		send_request(OP_RELEASE, '1);
		send_request(OP_RELEASE, 12'd100);
		send_request(OP_UNDEF, 12'hABC);
		send_request(OP_UNDEF, 12'h543);

		// eight-block window: fill it, then one more allocation fails
		wait_drained();
		write_active_bytes(10'd1);
		repeat (7) send_request(OP_ALLOC, '0);

		wait_drained();
		write_active_bytes(10'd0);
		send_request(OP_ALLOC, '0);
		send_request(OP_MARK, '0);

		wait_drained();
		write_active_bytes('1);
		send_request(OP_ALLOC, '0);

		for (int i = 0; i < NUM_PHASES; i++) begin
			bytes = (i == 8) ? CFG_W'($urandom_range(5, 1023)) : CFG_W'(PHASE_BYTES[i]);
			steady = (i == STEADY_PHASE);
			random_phase(bytes, PHASE_ITEMS);
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (book.pending() != 0)
			book.report_mismatch($sformatf("%0d results never arrived", book.pending()));

		if (book.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
